// ===== src/bgs_pkg.sv =====
// shared types and codes of the bilinear grid sampler
package bgs_pkg;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic
    {
        CFG_GRID_COLS = 1'b0,
        CFG_GRID_ROWS = 1'b1
    } cfg_index_t;

    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 8'd128;
    localparam int VALUE_W = 32;
    localparam int QUERY_W = 15;
    localparam int INDEX_W = 7;
    // wide enough for any coordinate integer part and any grid dimension
    localparam int DIM_W = 16;

    typedef struct packed
    {
        opcode_t                    opcode;
        logic [INDEX_W-1:0]         write_col;
        logic [INDEX_W-1:0]         write_row;
        logic signed [VALUE_W-1:0]  write_value;
        logic [QUERY_W-1:0]         query_x;
        logic [QUERY_W-1:0]         query_y;
    } in_item_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0]  sample_value;
        logic                       out_of_range;
    } out_item_t;

    // per-item control decoded at the front
    typedef struct packed
    {
        logic is_query;
        logic flagged;
        logic row_odd;
        logic col_odd;
    } bgs_ctl_t;

endpackage

// ===== src/bgs_bank_ram.sv =====
// one bank of grid storage: single port, registered read
module bgs_bank_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bgs_decode.sv =====
// front decode: bounds check, bank parities and bank addresses of an item
module bgs_decode #(
    parameter int GRID_COLS       = 128,
    parameter int GRID_ROWS       = 128,
    parameter int COORD_FRAC_BITS = 8,
    parameter int ADDR_W          = 12
) (
    input  bgs_pkg::in_item_t                item,
    input  logic [bgs_pkg::CFG_W-1:0]        cols_in_use,
    input  logic [bgs_pkg::CFG_W-1:0]        rows_in_use,
    output bgs_pkg::bgs_ctl_t                ctl,
    output logic [3:0][ADDR_W-1:0]           addr,
    output logic [COORD_FRAC_BITS-1:0]       fx,
    output logic [COORD_FRAC_BITS-1:0]       fy
);

    import bgs_pkg::*;

    localparam int HALF_COLS = (GRID_COLS + 1) / 2;

    logic [DIM_W-1:0] qx_ext;
    logic [DIM_W-1:0] qy_ext;
    logic [DIM_W-1:0] x1;
    logic [DIM_W-1:0] y1;
    logic [DIM_W-1:0] cols_lim;
    logic [DIM_W-1:0] rows_lim;
    logic [DIM_W-1:0] wcol;
    logic [DIM_W-1:0] wrow;

    assign qx_ext = DIM_W'(item.query_x);
    assign qy_ext = DIM_W'(item.query_y);
    assign x1 = qx_ext >> COORD_FRAC_BITS;
    assign y1 = qy_ext >> COORD_FRAC_BITS;
    assign fx = qx_ext[COORD_FRAC_BITS-1:0];
    assign fy = qy_ext[COORD_FRAC_BITS-1:0];
    assign wcol = DIM_W'(item.write_col);
    assign wrow = DIM_W'(item.write_row);

    // register values above the built grid act as the built size
    assign cols_lim = (DIM_W'(cols_in_use) > DIM_W'(GRID_COLS)) ?
                      DIM_W'(GRID_COLS) : DIM_W'(cols_in_use);
    assign rows_lim = (DIM_W'(rows_in_use) > DIM_W'(GRID_ROWS)) ?
                      DIM_W'(GRID_ROWS) : DIM_W'(rows_in_use);

    always_comb
    begin
        ctl.is_query = (item.opcode == OP_SAMPLE);
        if (ctl.is_query)
        begin
            ctl.flagged = ((x1 + 1'b1) >= cols_lim) || ((y1 + 1'b1) >= rows_lim);
            ctl.col_odd = x1[0];
            ctl.row_odd = y1[0];
        end
        else
        begin
            // writes outside the built grid are dropped
            ctl.flagged = (wcol >= DIM_W'(GRID_COLS)) || (wrow >= DIM_W'(GRID_ROWS));
            ctl.col_odd = wcol[0];
            ctl.row_odd = wrow[0];
        end
    end

    // even banks hold the neighbor at (x1+1)>>1 when x1 is odd
    always_comb
    begin
        logic [DIM_W-1:0] rh;
        logic [DIM_W-1:0] ch;
        logic [31:0]      lin;
        logic [1:0]       bsel;
        for (int b = 0; b < 4; b++)
        begin
            bsel = 2'(b);
            if (ctl.is_query)
            begin
                rh = bsel[1] ? (y1 >> 1) : ((y1 + 1'b1) >> 1);
                ch = bsel[0] ? (x1 >> 1) : ((x1 + 1'b1) >> 1);
            end
            else
            begin
                rh = wrow >> 1;
                ch = wcol >> 1;
            end
            lin = 32'(rh) * 32'(HALF_COLS) + 32'(ch);
            addr[b] = lin[ADDR_W-1:0];
        end
    end

endmodule

// ===== src/bilinear_grid_sampler.sv =====
// top level of the bilinear grid sampler: config, pipeline and grid banks
//
// Usage: one item channel (item_valid/item_ready/item) carries grid writes
// (opcode OP_WRITE) and sample queries (OP_SAMPLE). Writes load one grid
// entry and give no result; each query gives one transfer on the result
// channel (result_valid/result_ready/result), in query order. Grid size in
// use is set through cfg_we/cfg_index/cfg_data while the block is idle.
// Throughput is one item per cycle: the grid is split into four banks by
// column and row parity, so the four neighbors of a query come from four
// single-port banks in the same cycle, and a write takes one bank port.
// Five register stages: decode register (loaded by the item transfer), bank
// read, four weight multiplies, pair sums, final sum and shift into the
// output register; result_valid is the valid bit of that output register.
// Reset clears all valid bits and sets both dimensions to 128; grid contents
// are not cleared and an entry must be written before it is sampled.
// When result_ready is low the output holds and earlier stages keep
// filling their empty slots; item_ready drops only once the whole pipeline
// is full, and no item is lost or repeated across a stall.
module bilinear_grid_sampler #(
    parameter int GRID_COLS       = 128,
    parameter int GRID_ROWS       = 128,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  bgs_pkg::in_item_t            item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output bgs_pkg::out_item_t           result,
    input  logic                         cfg_we,
    input  bgs_pkg::cfg_index_t          cfg_index,
    input  logic [bgs_pkg::CFG_W-1:0]    cfg_data
);

    import bgs_pkg::*;

    localparam int F          = COORD_FRAC_BITS;
    localparam int HALF_COLS  = (GRID_COLS + 1) / 2;
    localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
    localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WGT_W      = 2 * F + 1;
    localparam int PROD_W     = VALUE_W + WGT_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT      = 2 * F;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // configuration
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= GRID_DIM_RESET;
            rows_reg <= GRID_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_COLS: cols_reg <= cfg_data;
                CFG_GRID_ROWS: rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || result_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign item_ready = en1;

    // stage 1: decode
    bgs_ctl_t               dec_ctl;
    logic [3:0][ADDR_W-1:0] dec_addr;
    logic [F-1:0]           dec_fx;
    logic [F-1:0]           dec_fy;

    bgs_decode #(
        .GRID_COLS       (GRID_COLS),
        .GRID_ROWS       (GRID_ROWS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ADDR_W          (ADDR_W)
    ) u_decode (
        .item        (item),
        .cols_in_use (cols_reg),
        .rows_in_use (rows_reg),
        .ctl         (dec_ctl),
        .addr        (dec_addr),
        .fx          (dec_fx),
        .fy          (dec_fy)
    );

    bgs_ctl_t               ctl1_reg;
    logic [3:0][ADDR_W-1:0] addr1_reg;
    logic [VALUE_W-1:0]     wdata1_reg;
    logic [F-1:0]           fx1_reg;
    logic [F-1:0]           fy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && en1)
        begin
            ctl1_reg   <= dec_ctl;
            addr1_reg  <= dec_addr;
            wdata1_reg <= item.write_value;
            fx1_reg    <= dec_fx;
            fy1_reg    <= dec_fy;
        end
    end

    // grid banks, index {row parity, column parity}
    logic                move1;
    logic [VALUE_W-1:0]  bank_rdata [4];

    assign move1 = v1_reg && en2 && !ctl1_reg.flagged;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic hit;
        assign hit = ({ctl1_reg.row_odd, ctl1_reg.col_odd} == 2'(b));

        bgs_bank_ram #(
            .DEPTH  (BANK_DEPTH),
            .ADDR_W (ADDR_W),
            .DATA_W (VALUE_W)
        ) u_ram (
            .clk   (clk),
            .en    (move1 && (ctl1_reg.is_query || hit)),
            .we    (!ctl1_reg.is_query),
            .addr  (addr1_reg[b]),
            .wdata (wdata1_reg),
            .rdata (bank_rdata[b])
        );
    end

    // stage 2: bank data and weights; index bit0 = right, bit1 = lower
    logic [F:0]       gx1;
    logic [F:0]       gy1;
    logic [WGT_W-1:0] wgt_next [4];
    logic [WGT_W-1:0] wgt2_reg [4];
    bgs_ctl_t         ctl2_reg;

    assign gx1 = ONE - {1'b0, fx1_reg};
    assign gy1 = ONE - {1'b0, fy1_reg};

    always_comb
    begin
        logic [F:0]        wx;
        logic [F:0]        wy;
        logic [2*F+1:0]    full;
        logic [1:0]        k2;
        for (int k = 0; k < 4; k++)
        begin
            k2 = 2'(k);
            wx = k2[0] ? {1'b0, fx1_reg} : gx1;
            wy = k2[1] ? {1'b0, fy1_reg} : gy1;
            full = wx * wy;
            wgt_next[k] = full[WGT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg && ctl1_reg.is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && en2)
        begin
            ctl2_reg <= ctl1_reg;
            for (int k = 0; k < 4; k++)
            begin
                wgt2_reg[k] <= wgt_next[k];
            end
        end
    end

    // stage 3: weighted neighbors
    logic signed [PROD_W-1:0] prod_next [4];
    logic signed [PROD_W-1:0] prod3_reg [4];
    logic                     flag3_reg;

    always_comb
    begin
        logic [1:0]                k2;
        logic [1:0]                bsel;
        logic signed [VALUE_W-1:0] q;
        for (int k = 0; k < 4; k++)
        begin
            k2 = 2'(k);
            bsel = {ctl2_reg.row_odd ^ k2[1], ctl2_reg.col_odd ^ k2[0]};
            q = $signed(bank_rdata[bsel]);
            prod_next[k] = q * $signed({1'b0, wgt2_reg[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && en3)
        begin
            flag3_reg <= ctl2_reg.flagged;
            for (int k = 0; k < 4; k++)
            begin
                prod3_reg[k] <= prod_next[k];
            end
        end
    end

    // stage 4: pair sums
    logic signed [SUM_W-1:0] upper4_reg;
    logic signed [SUM_W-1:0] lower4_reg;
    logic                    flag4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && en4)
        begin
            flag4_reg  <= flag3_reg;
            upper4_reg <= SUM_W'(prod3_reg[0]) + SUM_W'(prod3_reg[1]);
            lower4_reg <= SUM_W'(prod3_reg[2]) + SUM_W'(prod3_reg[3]);
        end
    end

    // stage 5: total, floor shift back to map format
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] scaled;
    out_item_t               result_reg;

    assign total  = upper4_reg + lower4_reg;
    assign scaled = total >>> SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en5)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg && en5)
        begin
            result_reg.out_of_range <= flag4_reg;
            result_reg.sample_value <= flag4_reg ? '0 : scaled[VALUE_W-1:0];
        end
    end

    assign result_valid = v5_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // a full decode slot is the only reason to refuse an item
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> v1_reg)
        else $error("item_ready low with empty decode stage");

    // writes retire at the bank and never reach the read stage
    a_write_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en2 && !ctl1_reg.is_query) |=> !v2_reg)
        else $error("write item entered read stage");

    // a stalled read stage keeps its query
    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en3) |=> (v2_reg && $stable(ctl2_reg)))
        else $error("read stage lost its query during stall");

    // flagged results carry a zero value
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_of_range) |-> (result.sample_value == '0))
        else $error("flagged result with nonzero value");
`endif

endmodule

// ===== sim/bilinear_grid_sampler_tb.sv =====
// testbench for the bilinear grid sampler: directed table, random traffic, self-checking
module bilinear_grid_sampler_tb;
    import bgs_pkg::*;

    localparam int GRID_COLS       = 128;
    localparam int GRID_ROWS       = 128;
    localparam int FRAC_BITS       = 8;
    localparam int GRID_DEPTH      = GRID_COLS * GRID_ROWS;
    localparam int QUERY_MAX       = (1 << QUERY_W) - 1;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 6;
    localparam int STEPS_PER_PHASE = 110;

    typedef struct
    {
        bit                 is_cfg;
        cfg_index_t         cfg_sel;
        logic [CFG_W-1:0]   cfg_val;
        in_item_t           item;
        bit                 typed;
        out_item_t          want;
    } stim_row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    in_item_t           item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    out_item_t          result;
    logic               cfg_we = 1'b0;
    cfg_index_t         cfg_index = CFG_GRID_COLS;
    logic [CFG_W-1:0]   cfg_data = '0;

    // mirror of the grid and the size registers
    logic signed [VALUE_W-1:0]  grid_mem [GRID_DEPTH];
    bit                         grid_written [GRID_DEPTH];
    logic [CFG_W-1:0]           cols_in_use = GRID_DIM_RESET;
    logic [CFG_W-1:0]           rows_in_use = GRID_DIM_RESET;

    stim_row_t  stim_table [$];
    out_item_t  expected_samples [$];

    bit send_idle_en  = 1'b1;
    bit recv_stall_en = 1'b1;
    bit hold_off_req  = 1'b0;

    int items_sent      = 0;
    int writes_sent     = 0;
    int flagged_sent    = 0;
    int samples_checked = 0;
    int config_writes   = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    bilinear_grid_sampler #(
        .GRID_COLS       (GRID_COLS),
        .GRID_ROWS       (GRID_ROWS),
        .COORD_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] reg_val, int limit);
        return (int'(reg_val) > limit) ? limit : int'(reg_val);
    endfunction

    // the right and lower neighbors are needed even when their weight is zero
    function automatic bit query_flagged(logic [QUERY_W-1:0] qx, logic [QUERY_W-1:0] qy);
        return (int'(qx >> FRAC_BITS) + 1 >= eff_dim(cols_in_use, GRID_COLS))
            || (int'(qy >> FRAC_BITS) + 1 >= eff_dim(rows_in_use, GRID_ROWS));
    endfunction

    function automatic out_item_t predict_sample(logic [QUERY_W-1:0] qx,
                                                 logic [QUERY_W-1:0] qy);
        int         idx;
        longint     fx, fy, gx, gy, acc;
        out_item_t  r;
        r = '0;
        if (query_flagged(qx, qy))
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        idx = int'(qy >> FRAC_BITS) * GRID_COLS + int'(qx >> FRAC_BITS);
        fx  = qx[FRAC_BITS-1:0];
        fy  = qy[FRAC_BITS-1:0];
        gx  = (1 << FRAC_BITS) - fx;
        gy  = (1 << FRAC_BITS) - fy;
        acc = longint'(grid_mem[idx]) * gx * gy
            + longint'(grid_mem[idx + 1]) * fx * gy
            + longint'(grid_mem[idx + GRID_COLS]) * gx * fy
            + longint'(grid_mem[idx + GRID_COLS + 1]) * fx * fy;
        // arithmetic shift floors toward minus infinity
        r.sample_value = 32'(acc >>> (2 * FRAC_BITS));
        return r;
    endfunction

    // called once the item transfer has happened
    function automatic void apply_item(in_item_t it, bit typed, out_item_t want);
        out_item_t  next_sample;
        int         idx;
        items_sent++;
        if (it.opcode == OP_WRITE)
        begin
            idx = int'(it.write_row) * GRID_COLS + int'(it.write_col);
            grid_mem[idx]     = it.write_value;
            grid_written[idx] = 1'b1;
            writes_sent++;
        end
        else
        begin
            next_sample = typed ? want : predict_sample(it.query_x, it.query_y);
            if (next_sample.out_of_range)
                flagged_sent++;
            expected_samples = {expected_samples, next_sample};
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_map_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] random_frac();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return FRAC_BITS'($urandom_range((1 << FRAC_BITS) - 1));
        endcase
    endfunction

    // fields the opcode does not use carry random bits
    function automatic in_item_t write_item(int col, int row, logic [VALUE_W-1:0] value);
        in_item_t it;
        it.opcode      = OP_WRITE;
        it.write_col   = INDEX_W'(col);
        it.write_row   = INDEX_W'(row);
        it.write_value = value;
        it.query_x     = QUERY_W'($urandom);
        it.query_y     = QUERY_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t query_item(int qx, int qy);
        in_item_t it;
        it.opcode      = OP_SAMPLE;
        it.write_col   = INDEX_W'($urandom);
        it.write_row   = INDEX_W'($urandom);
        it.write_value = $urandom;
        it.query_x     = QUERY_W'(qx);
        it.query_y     = QUERY_W'(qy);
        return it;
    endfunction

    function automatic void add_row(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_sel = CFG_GRID_COLS;
        r.cfg_val = '0;
        r.item    = it;
        r.typed   = typed;
        r.want    = want;
        stim_table = {stim_table, r};
    endfunction

    function automatic void add_cfg(cfg_index_t sel, logic [CFG_W-1:0] val);
        stim_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_sel = sel;
        r.cfg_val = val;
        r.item    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        stim_table = {stim_table, r};
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        if (send_idle_en && $urandom_range(99) < 23)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        apply_item(it, typed, want);
    endtask

    // writes give no result, so the drain covers any still in flight
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(cfg_index_t sel, logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_GRID_COLS)
            cols_in_use = val;
        else
            rows_in_use = val;
        config_writes++;
    endtask

    task automatic send_query(int qx, int qy);
        int base, idx;
        if (!query_flagged(QUERY_W'(qx), QUERY_W'(qy)))
        begin
            base = (qy >> FRAC_BITS) * GRID_COLS + (qx >> FRAC_BITS);
            // fill any neighbor that has never held a value
            for (int k = 0; k < 4; k++)
            begin
                idx = base + (k / 2) * GRID_COLS + (k % 2);
                if (!grid_written[idx])
                    send_item(write_item(idx % GRID_COLS, idx / GRID_COLS,
                                         random_map_value()), 1'b0, '0);
            end
        end
        send_item(query_item(qx, qy), 1'b0, '0);
    endtask

    task automatic random_step();
        int mode, cols, rows, lim_x, lim_y, qx, qy;
        mode = $urandom_range(99);
        cols = eff_dim(cols_in_use, GRID_COLS);
        rows = eff_dim(rows_in_use, GRID_ROWS);
        if (mode < 12)
            send_item(write_item($urandom_range(9), $urandom_range(9), random_map_value()),
                      1'b0, '0);
        else if (mode < 20)
            send_item(write_item($urandom, $urandom, random_map_value()), 1'b0, '0);
        else if (mode < 75 && cols >= 2 && rows >= 2)
        begin
            // mostly near the origin so entries get reused and overwritten
            lim_x = (mode < 60 && cols - 2 > 9) ? 9 : cols - 2;
            lim_y = (mode < 60 && rows - 2 > 9) ? 9 : rows - 2;
            qx = ($urandom_range(lim_x) << FRAC_BITS) + random_frac();
            qy = ($urandom_range(lim_y) << FRAC_BITS) + random_frac();
            send_query(qx, qy);
        end
        else if (mode < 90)
        begin
            if ($urandom_range(1))
            begin
                qx = $urandom_range(QUERY_MAX, cols < 1 ? 0 : (cols - 1) << FRAC_BITS);
                qy = $urandom_range(QUERY_MAX);
            end
            else
            begin
                qx = $urandom_range(QUERY_MAX);
                qy = $urandom_range(QUERY_MAX, rows < 1 ? 0 : (rows - 1) << FRAC_BITS);
            end
            send_query(qx, qy);
        end
        else
            send_query($urandom_range(QUERY_MAX), $urandom_range(QUERY_MAX));
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            result_ready <= !(recv_stall_en && $urandom_range(99) < 23);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("result transfer with no sample pending: sample_value %0d out_of_range %0b",
                       result.sample_value, result.out_of_range);
                mismatch_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (result.sample_value !== want.sample_value)
                begin
                    $error("sample_value: expected %0d, actual %0d",
                           want.sample_value, result.sample_value);
                    mismatch_count++;
                end
                if (result.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0b, actual %0b",
                           want.out_of_range, result.out_of_range);
                    mismatch_count++;
                end
                samples_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $error("no transfer for %0d cycles, %0d samples pending",
               quiet_cycles, expected_samples.size());
        $display("bilinear_grid_sampler_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] phase_cols [NUM_PHASES];
        logic [CFG_W-1:0] phase_rows [NUM_PHASES];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 patch at the origin with the value extremes
        add_row(write_item(0, 0, 32'h7FFF_FFFF));
        add_row(write_item(1, 0, 32'h8000_0000));
        add_row(write_item(0, 1, 32'h0000_0000));
        add_row(write_item(1, 1, 32'hFFFF_FFFF));
        add_row(query_item(16'h0000, 16'h0000), 1'b1,
                '{sample_value: 32'h7FFF_FFFF, out_of_range: 1'b0});
        add_row(query_item(16'h00FF, 16'h00FF));
        add_row(query_item(16'h0080, 16'h0000));
        add_row(query_item(16'h0000, 16'h0080));
        add_row(write_item(0, 0, 32'h8000_0000));
        add_row(query_item(16'h0000, 16'h0000), 1'b1,
                '{sample_value: 32'h8000_0000, out_of_range: 1'b0});
        // far corner of the grid
        add_row(write_item(126, 126, random_map_value()));
        add_row(write_item(127, 126, random_map_value()));
        add_row(write_item(126, 127, random_map_value()));
        add_row(write_item(127, 127, random_map_value()));
        add_row(query_item(16'h7EFF, 16'h7EFF));
        // exactly on the last column or row still needs the missing neighbor
        add_row(query_item(16'h7F00, 16'h0000), 1'b1, '{sample_value: '0, out_of_range: 1'b1});
        add_row(query_item(16'h0000, 16'h7F00), 1'b1, '{sample_value: '0, out_of_range: 1'b1});
        add_row(query_item(16'h7FFF, 16'h7FFF), 1'b1, '{sample_value: '0, out_of_range: 1'b1});
        // register above the grid size acts as the full size
        add_cfg(CFG_GRID_COLS, 8'd255);
        add_cfg(CFG_GRID_ROWS, 8'd255);
        add_row(query_item(16'h7EFF, 16'h7E80));
        add_cfg(CFG_GRID_COLS, 8'd2);
        add_row(query_item(16'h00FF, 16'h0040));
        add_row(query_item(16'h0100, 16'h0000), 1'b1, '{sample_value: '0, out_of_range: 1'b1});
        // fewer than two rows or columns flags everything
        add_cfg(CFG_GRID_ROWS, 8'd1);
        add_row(query_item(16'h0000, 16'h0000), 1'b1, '{sample_value: '0, out_of_range: 1'b1});
        add_cfg(CFG_GRID_COLS, 8'd0);
        add_cfg(CFG_GRID_ROWS, 8'd0);
        add_row(query_item(16'h00FF, 16'h00FF), 1'b1, '{sample_value: '0, out_of_range: 1'b1});
        add_cfg(CFG_GRID_COLS, 8'd128);
        add_cfg(CFG_GRID_ROWS, 8'd128);
        add_row(query_item(16'h0040, 16'h00C0));

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                write_config(stim_table[i].cfg_sel, stim_table[i].cfg_val);
            else
                send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
        end

        phase_cols[0] = 8'd128;  phase_rows[0] = 8'd128;
        phase_cols[1] = 8'd2;    phase_rows[1] = 8'd2;
        phase_cols[2] = 8'd255;  phase_rows[2] = CFG_W'($urandom_range(2, 128));
        phase_cols[3] = 8'd3;    phase_rows[3] = 8'd255;
        phase_cols[4] = 8'd128;  phase_rows[4] = 8'd1;
        phase_cols[5] = CFG_W'($urandom_range(2, 128));
        phase_rows[5] = CFG_W'($urandom_range(2, 128));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_config(CFG_GRID_COLS, phase_cols[p]);
            write_config(CFG_GRID_ROWS, phase_rows[p]);
            // one phase runs at full rate on both sides
            send_idle_en  = (p != 2);
            recv_stall_en = (p != 2);
            if (p == 3)
                hold_off_req = 1'b1;
            for (int n = 0; n < STEPS_PER_PHASE; n++)
            begin
                if (p == 1 && n == STEPS_PER_PHASE / 2)
                    wait_idle();
                random_step();
            end
        end

        wait_idle();
        $display("run covered %0d items: %0d grid writes, %0d samples checked, %0d flagged",
                 items_sent, writes_sent, samples_checked, flagged_sent);
        $display("grid size written %0d times, dimensions from 0 to 255, one %0d-cycle hold-off",
                 config_writes, HOLD_OFF_CYCLES);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("bilinear_grid_sampler_tb: PASS");
        else
            $display("bilinear_grid_sampler_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bgs_pkg.sv
src/bgs_bank_ram.sv
src/bgs_decode.sv
src/bilinear_grid_sampler.sv
sim/bilinear_grid_sampler_tb.sv
